FILE: sv/ycgp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycgp_pkg
// Shared types and constants of the luma gamma pixel pipeline.
// ----------------------------------------------------------------------------
package ycgp_pkg;

    localparam logic [15:0] Y_REF_Q8 = 16'd60160;  // 235.0 in Q8.8
    localparam logic [15:0] Y_MIN_Q8 = 16'd4096;   // 16.0 in Q8.8
    localparam logic [15:0] C_MID_Q8 = 16'd32768;  // 128.0 in Q8.8
    localparam logic [15:0] GAMMA_RESET = 16'd4096;

    // log2 in Q16 of a 16-bit value, same squaring scheme as the datapath
    function automatic logic [19:0] log2_q16_f(input logic [15:0] v);
        logic [63:0] m;
        logic [15:0] frac;
        logic [3:0]  p;
        p    = '0;
        frac = '0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) p = 4'(i);
        end
        m = 64'(v) << (30 - int'(p));
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m       = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return {p, frac};
    endfunction

    localparam logic [19:0] LOG_REF = log2_q16_f(Y_REF_Q8);

    typedef struct packed {
        logic [15:0] cb;
        logic [15:0] cr;
    } t_chroma;

    typedef struct packed {
        logic        valid;
        logic [15:0] yq;
        t_chroma     ch;
    } t_csc;

    typedef struct packed {
        logic        valid;
        logic [19:0] lg;
        t_chroma     ch;
    } t_lgo;

    typedef struct packed {
        logic        valid;
        logic [15:0] y;
        t_chroma     ch;
    } t_luma;

    typedef struct packed {
        logic       valid;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

endpackage

FILE: sv/ycgp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycgp_in_if
// Input pixel channel: valid/ready with one RGB pixel.
// ----------------------------------------------------------------------------
interface ycgp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

FILE: sv/ycgp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycgp_out_if
// Output pixel channel: valid/ready with one RGB pixel.
// ----------------------------------------------------------------------------
interface ycgp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

FILE: sv/ycbcr_luma_gamma_pixel.sv
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while the skid slot is empty, set by the
// 496-stage square-root chain that retires one result bit per stage.
// Reset (synchronous, i_rst_n low): all valid bits and the output buffer
// clear, gamma returns to 1.0 (4096).
// ----------------------------------------------------------------------------
// ycbcr_luma_gamma_pixel
// BT.601 luma gamma correction of an RGB pixel stream.
// ----------------------------------------------------------------------------
module ycbcr_luma_gamma_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_gamma_q12_we,
    input  logic [15:0] i_gamma_q12,
    ycgp_in_if.sink     i_pix,
    ycgp_out_if.source  o_pix
);
    import ycgp_pkg::*;

    // Gamma register; the user must only write it while the pipe is empty, the block does not enforce it.
    logic [15:0] r_gamma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
        end else if (i_gamma_q12_we) begin
            r_gamma <= i_gamma_q12;
        end
    end

    // Output register plus one skid slot. A result that meets a stalled
    // output parks in the skid slot; the pipe then holds until it drains.
    t_rgb r_out;
    t_rgb r_skid;
    logic r_out_valid;
    logic r_skid_valid;

    // Whole pipe advances together; it only stops when the skid slot is
    // full, so the ready path is a single register.
    logic  ce;
    assign ce          = !r_skid_valid;
    assign i_pix.ready = ce;

    t_csc  csc;
    t_lgo  lgo;
    t_luma luma;
    t_rgb  rgb;

    ycgp_csc u_csc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_pix.valid),
        .i_red   (i_pix.red_in),
        .i_green (i_pix.green_in),
        .i_blue  (i_pix.blue_in),
        .o_csc   (csc)
    );

    ycgp_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_csc   (csc),
        .o_lgo   (lgo)
    );

    ycgp_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_gamma (r_gamma),
        .i_lgo   (lgo),
        .o_luma  (luma)
    );

    ycgp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_luma  (luma),
        .o_rgb   (rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_pix.ready) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (rgb.valid) begin
            if (!r_out_valid || o_pix.ready) begin
                r_out       <= rgb;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= rgb;
                r_skid_valid <= 1'b1;
            end
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.red_out   = r_out.r;
    assign o_pix.green_out = r_out.g;
    assign o_pix.blue_out  = r_out.b;
endmodule

FILE: sv/ycgp_csc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycgp_csc
// RGB to studio-range YCbCr, Q8.8 rounded, one register stage.
// ----------------------------------------------------------------------------
module ycgp_csc (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_ce,
    input  logic         i_valid,
    input  logic [7:0]   i_red,
    input  logic [7:0]   i_green,
    input  logic [7:0]   i_blue,
    output ycgp_pkg::t_csc o_csc
);
    import ycgp_pkg::*;

    logic [20:0] y12, cb12, cr12;
    logic [20:0] y_rnd, cb_rnd, cr_rnd;
    t_csc        r_csc;

    always_comb begin
        y12  = 21'd1053 * 21'(i_red) + 21'd2064 * 21'(i_green) + 21'd401 * 21'(i_blue)
             + 21'd65536;
        cb12 = 21'd1798 * 21'(i_blue) + 21'd524288
             - 21'd606 * 21'(i_red) - 21'd1192 * 21'(i_green);
        cr12 = 21'd1798 * 21'(i_red) + 21'd524288
             - 21'd1507 * 21'(i_green) - 21'd291 * 21'(i_blue);
        y_rnd  = y12 + 21'd8;
        cb_rnd = cb12 + 21'd8;
        cr_rnd = cr12 + 21'd8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csc.valid <= 1'b0;
        end else if (i_ce) begin
            r_csc.valid <= i_valid;
            r_csc.yq    <= y_rnd[19:4];
            r_csc.ch.cb <= cb_rnd[19:4];
            r_csc.ch.cr <= cr_rnd[19:4];
        end
    end

    assign o_csc = r_csc;
endmodule

FILE: sv/ycgp_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycgp_log
// log2 of luma in Q16: normalize stage, then one squaring per stage.
// ----------------------------------------------------------------------------
module ycgp_log (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  ycgp_pkg::t_csc i_csc,
    output ycgp_pkg::t_lgo o_lgo
);
    import ycgp_pkg::*;

    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic        valid;
        logic [3:0]  p;
        logic [30:0] m;
        logic [15:0] frac;
        t_chroma     ch;
    } t_lstage;

    t_lstage     r_ls [FRAC_BITS+1];
    logic [3:0]  msb;
    t_lstage     head;

    always_comb begin
        msb = '0;
        for (int i = 0; i < 16; i++) begin
            if (i_csc.yq[i]) msb = 4'(i);
        end
        head.valid = i_csc.valid;
        head.p     = msb;
        head.m     = {i_csc.yq, 15'b0} << (4'd15 - msb);
        head.frac  = '0;
        head.ch    = i_csc.ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ls[0].valid <= 1'b0;
        end else if (i_ce) begin
            r_ls[0] <= head;
        end
    end

    for (genvar s = 0; s < FRAC_BITS; s++) begin : g_sq
        localparam int BIT = FRAC_BITS - 1 - s;
        logic [61:0] sq;
        t_lstage     nx;

        always_comb begin
            nx = r_ls[s];
            sq = {31'b0, r_ls[s].m} * {31'b0, r_ls[s].m};
            if (sq[61]) begin
                nx.m         = sq[61:31];
                nx.frac[BIT] = 1'b1;
            end else begin
                nx.m = sq[60:30];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ls[s+1].valid <= 1'b0;
            end else if (i_ce) begin
                r_ls[s+1] <= nx;
            end
        end
    end

    assign o_lgo.valid = r_ls[FRAC_BITS].valid;
    assign o_lgo.lg    = {r_ls[FRAC_BITS].p, r_ls[FRAC_BITS].frac};
    assign o_lgo.ch    = r_ls[FRAC_BITS].ch;
endmodule

FILE: sv/ycgp_pow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycgp_pow
// New luma 235*2^-(gamma*dlog): exponent multiply, 16 chained square roots
// one result bit per stage, scale and clamp.
// ----------------------------------------------------------------------------
module ycgp_pow (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic [15:0]    i_gamma,
    input  ycgp_pkg::t_lgo i_lgo,
    output ycgp_pkg::t_luma o_luma
);
    import ycgp_pkg::*;

    localparam int ROOTS     = 16;
    localparam int SQ_STEPS  = 31;
    localparam int SQ_STAGES = ROOTS * SQ_STEPS;

    localparam logic [1:0] MODE_POW  = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_LOW  = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [1:0]  mode;
        logic [17:0] nl;
        t_chroma     ch;
    } t_dlog;

    typedef struct packed {
        logic        valid;
        logic [1:0]  mode;
        logic [30:0] x;
        logic [30:0] q;
        logic [31:0] rem;
        logic [15:0] f;
        logic [1:0]  k;
        t_chroma     ch;
    } t_root;

    typedef struct packed {
        logic        valid;
        logic [1:0]  mode;
        logic [46:0] prod;
        t_chroma     ch;
    } t_scale;

    t_dlog       r_dl;
    t_root       r_rt [SQ_STAGES+1];
    t_scale      r_sc;
    t_luma       r_out;

    // stage A: log difference, saturate when luma reaches the reference
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl.valid <= 1'b0;
        end else if (i_ce) begin
            r_dl.valid <= i_lgo.valid;
            r_dl.mode  <= (i_lgo.lg >= LOG_REF) ? MODE_HIGH : MODE_POW;
            r_dl.nl    <= 18'(LOG_REF - i_lgo.lg);
            r_dl.ch    <= i_lgo.ch;
        end
    end

    // stage B: exponent n = round(dlog * gamma)
    logic [34:0] n_prod;
    logic [22:0] n_exp;
    t_root       head;

    always_comb begin
        n_prod     = 35'(r_dl.nl) * 35'(i_gamma) + 35'd2048;
        n_exp      = n_prod[34:12];
        head       = '0;
        head.valid = r_dl.valid;
        head.mode  = r_dl.mode;
        if (r_dl.mode == MODE_POW && n_exp[22:18] != 5'd0) head.mode = MODE_LOW;
        head.f     = n_exp[15:0];
        head.k     = n_exp[17:16];
        head.ch    = r_dl.ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt[0].valid <= 1'b0;
        end else if (i_ce) begin
            r_rt[0] <= head;
        end
    end

    // square-root chain; each root takes 31 stages
    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_root
        localparam int G = s / SQ_STEPS;
        localparam int J = s % SQ_STEPS;
        localparam int P = 30 - J;
        t_root       nx;
        logic [30:0] rp;
        logic [61:0] nw;
        logic [33:0] rsh, trial;

        always_comb begin
            nx = r_rt[s];
            rp = '0;
            if (J == 0) begin
                rp     = (G == 0) ? 31'h4000_0000 : r_rt[s].q;
                nx.x   = r_rt[s].f[G] ? (rp >> 1) : rp;
                nx.q   = '0;
                nx.rem = '0;
            end
            nw    = {1'b0, nx.x, 30'b0};
            rsh   = {nx.rem, nw[2*P+1 -: 2]};
            trial = {1'b0, nx.q, 2'b01};
            if (rsh >= trial) begin
                nx.rem = 32'(rsh - trial);
                nx.q   = {nx.q[29:0], 1'b1};
            end else begin
                nx.rem = rsh[31:0];
                nx.q   = {nx.q[29:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt[s+1].valid <= 1'b0;
            end else if (i_ce) begin
                r_rt[s+1] <= nx;
            end
        end
    end

    // stage E1: integer part of the exponent, scale by 235
    logic [30:0] q_k;
    assign q_k = r_rt[SQ_STAGES].q >> r_rt[SQ_STAGES].k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc.valid <= 1'b0;
        end else if (i_ce) begin
            r_sc.valid <= r_rt[SQ_STAGES].valid;
            r_sc.mode  <= r_rt[SQ_STAGES].mode;
            r_sc.prod  <= 47'(Y_REF_Q8) * 47'(q_k);
            r_sc.ch    <= r_rt[SQ_STAGES].ch;
        end
    end

    // stage E2: round, special cases, clamp to 16..235
    logic [46:0] y_rnd;
    logic [16:0] y_pow;
    logic [15:0] y_new;

    always_comb begin
        y_rnd = r_sc.prod + 47'h2000_0000;
        y_pow = y_rnd[46:30];
        case (r_sc.mode)
            MODE_HIGH: y_new = Y_REF_Q8;
            MODE_LOW:  y_new = Y_MIN_Q8;
            MODE_POW: begin
                if (y_pow < 17'(Y_MIN_Q8))      y_new = Y_MIN_Q8;
                else if (y_pow > 17'(Y_REF_Q8)) y_new = Y_REF_Q8;
                else                            y_new = y_pow[15:0];
            end
            default:   y_new = Y_REF_Q8;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (i_ce) begin
            r_out.valid <= r_sc.valid;
            r_out.y     <= y_new;
            r_out.ch    <= r_sc.ch;
        end
    end

    assign o_luma = r_out;
endmodule

FILE: sv/ycgp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycgp_back
// YCbCr back to RGB in Q20: product stage, then sum and clamp stage.
// ----------------------------------------------------------------------------
module ycgp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ce,
    input  ycgp_pkg::t_luma i_luma,
    output ycgp_pkg::t_rgb  o_rgb
);
    import ycgp_pkg::*;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] py;
        logic signed [31:0] pr_cr;
        logic signed [31:0] pg_cb;
        logic signed [31:0] pg_cr;
        logic signed [31:0] pb_cb;
    } t_prod;

    function automatic logic [7:0] to_channel(input logic signed [31:0] v);
        if (v <= 32'sd0)          return 8'd0;
        else if (v[30:20] > 11'd255) return 8'd255;
        else                      return v[27:20];
    endfunction

    logic signed [31:0] yd, cbd, crd;
    t_prod              r_pr;
    t_rgb               r_rgb;

    always_comb begin
        yd  = $signed(32'(i_luma.y - Y_MIN_Q8));
        cbd = $signed(32'(i_luma.ch.cb)) - $signed(32'(C_MID_Q8));
        crd = $signed(32'(i_luma.ch.cr)) - $signed(32'(C_MID_Q8));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr.valid <= 1'b0;
        end else if (i_ce) begin
            r_pr.valid <= i_luma.valid;
            r_pr.py    <= 32'sd4768 * yd;
            r_pr.pr_cr <= 32'sd6537 * crd;
            r_pr.pg_cb <= 32'sd1606 * cbd;
            r_pr.pg_cr <= 32'sd3330 * crd;
            r_pr.pb_cb <= 32'sd8262 * cbd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rgb.valid <= 1'b0;
        end else if (i_ce) begin
            r_rgb.valid <= r_pr.valid;
            r_rgb.r     <= to_channel(r_pr.py + r_pr.pr_cr);
            r_rgb.g     <= to_channel(r_pr.py - r_pr.pg_cb - r_pr.pg_cr);
            r_rgb.b     <= to_channel(r_pr.py + r_pr.pb_cb);
        end
    end

    assign o_rgb = r_rgb;
endmodule

FILE: sv/ycgp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycgp_checker
// Port-level checks of the pixel pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module ycgp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_red,
    input logic [7:0] i_green,
    input logic [7:0] i_blue
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue)))
        else $error("stalled output request changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending output");

    a_stall_persists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_in_ready && !i_out_ready) |=> !i_in_ready)
        else $error("input stall released without output drain");

endmodule

bind ycbcr_luma_gamma_pixel ycgp_checker u_ycgp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red_out),
    .i_green     (o_pix.green_out),
    .i_blue      (o_pix.blue_out)
);
